// File: src/catmull_rom_color_spline_macros.svh
// assertion macros for the catmull-rom color spline
`ifndef CATMULL_ROM_COLOR_SPLINE_MACROS_SVH
`define CATMULL_ROM_COLOR_SPLINE_MACROS_SVH
`ifndef SYNTHESIS
`define CRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CRS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRS_ASSERT(label, clk, rst, prop, msg)
`define CRS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: src/crs_pkg.sv
// package: types, constants and helpers for the catmull-rom color spline
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;
   localparam int MaxKnots = 16;
   localparam int Channels = 3;
   localparam int FracBits = 15;
   localparam int KiW = $clog2(MaxKnots);
   localparam int ChW = 2;
   localparam int AddrW = $clog2(Channels * MaxKnots);
   localparam int SpanW = KiW;
   localparam int UW = FracBits + 1;
   localparam int QDepth = 8;
   localparam int QPtrW = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [1:0]         channel;
      logic [3:0]         knot_index;
      logic signed [15:0] knot_value;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] red;
      logic signed [15:0] green;
      logic signed [15:0] blue;
   } rsp_type;

   // classified work between front and back
   typedef struct packed {
      logic               is_eval;
      logic               wr_en;
      logic [AddrW-1:0]   wr_addr;
      logic signed [15:0] wr_data;
      logic               zero;
      logic [SpanW-1:0]   span;
      logic [UW-1:0]      u;
   } op_type;

   // rounded product shift, ties toward plus infinity
   function automatic logic signed [23:0] rnd_mul(input logic signed [23:0] h,
                                                  input logic [UW-1:0] u);
      logic signed [41:0] p;
      p = 42'(h) * $signed({1'b0, u});
      p = p + 42'(1 <<< (FracBits - 1));
      return 24'(p >>> FracBits);
   endfunction
endpackage
`default_nettype wire

// File: src/crs_front.sv
// front end: classifies requests, computes span and fraction
`timescale 1ns / 1ps
`default_nettype none
module crs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire crs_pkg::req_type   in_req,
   input  wire logic [4:0]         knot_count,
   output crs_pkg::op_type         op_ff
);
   localparam int XW = crs_pkg::UW + 4;
   crs_pkg::op_type op_in;
   logic signed [17:0] t15;
   logic [crs_pkg::UW-1:0] t;
   logic [4:0] kc;
   logic [3:0] nspans;
   logic [XW-1:0] x;
   logic [XW-crs_pkg::FracBits-1:0] sp;
   logic [crs_pkg::SpanW-1:0] span;

   always_comb begin
      t15 = 18'(in_req.sample) + 18'sd16384;
      if (t15 < 0) t = '0;
      else if (t15 > 18'sd32768) t = crs_pkg::UW'(32768);
      else t = crs_pkg::UW'(t15);
      kc = (knot_count > 5'(crs_pkg::MaxKnots)) ? 5'(crs_pkg::MaxKnots) : knot_count;
      nspans = 4'(kc - 5'd3);
      x = XW'(t) * XW'(nspans);
      sp = x[XW-1:crs_pkg::FracBits];
      if (sp > (XW-crs_pkg::FracBits)'(nspans - 4'd1)) span = nspans - 4'd1;
      else span = crs_pkg::SpanW'(sp);
      op_in.is_eval = in_valid && (in_req.cmd == crs_pkg::CMD_EVAL);
      op_in.wr_en = in_valid && (in_req.cmd == crs_pkg::CMD_WRITE)
                    && (in_req.channel < 2'(crs_pkg::Channels));
      op_in.wr_addr = crs_pkg::AddrW'({in_req.channel, in_req.knot_index});
      op_in.wr_data = in_req.knot_value;
      op_in.zero = (kc < 5'd4);
      op_in.span = span;
      op_in.u = crs_pkg::UW'(x - (XW'(span) << crs_pkg::FracBits));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.is_eval <= 1'b0;
         op_ff.wr_en <= 1'b0;
      end else begin
         op_ff.is_eval <= op_in.is_eval;
         op_ff.wr_en <= op_in.wr_en;
      end
      op_ff.wr_addr <= op_in.wr_addr;
      op_ff.wr_data <= op_in.wr_data;
      op_ff.zero <= op_in.zero;
      op_ff.span <= op_in.span;
      op_ff.u <= op_in.u;
   end
endmodule
`default_nettype wire

// File: src/crs_back.sv
// back end: knot tables and pipelined horner evaluation of three channels
`timescale 1ns / 1ps
`default_nettype none
`include "catmull_rom_color_spline_macros.svh"
module crs_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire crs_pkg::op_type  op,
   output logic                  res_valid,
   output crs_pkg::rsp_type      res
);
   localparam int NS = 5;
   // one table per channel so four knots are read at once
   logic signed [15:0] tbl_ff [crs_pkg::Channels][crs_pkg::MaxKnots];
   logic [NS-1:0] v_ff;
   logic zero_ff [NS];
   logic [crs_pkg::UW-1:0] u_ff [NS];
   logic signed [23:0] c_ff [crs_pkg::Channels][4];
   logic signed [23:0] h_ff [crs_pkg::Channels];
   logic signed [23:0] c2_ff [crs_pkg::Channels];
   logic signed [23:0] c1_ff [crs_pkg::Channels][2];
   logic signed [23:0] c0_ff [crs_pkg::Channels][2];
   logic signed [15:0] o_ff [crs_pkg::Channels];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[NS-2:0], op.is_eval};
   end

   always_ff @(posedge clock) begin
      logic signed [23:0] k0, k1, k2, k3, hf;
      if (op.wr_en)
         tbl_ff[op.wr_addr[crs_pkg::AddrW-1:crs_pkg::KiW]][op.wr_addr[crs_pkg::KiW-1:0]]
            <= op.wr_data;
      zero_ff[0] <= op.zero;
      u_ff[0] <= op.u;
      for (int i = 1; i < NS; i++) begin
         zero_ff[i] <= zero_ff[i-1];
         u_ff[i] <= u_ff[i-1];
      end
      for (int c = 0; c < crs_pkg::Channels; c++) begin
         k0 = 24'(tbl_ff[c][op.span]);
         k1 = 24'(tbl_ff[c][crs_pkg::KiW'(op.span + 1)]);
         k2 = 24'(tbl_ff[c][crs_pkg::KiW'(op.span + 2)]);
         k3 = 24'(tbl_ff[c][crs_pkg::KiW'(op.span + 3)]);
         // stage 0: coefficients, doubled
         c_ff[c][3] <= 24'(-k0 + 3*k1 - 3*k2 + k3);
         c_ff[c][2] <= 24'(2*k0 - 5*k1 + 4*k2 - k3);
         c_ff[c][1] <= k2 - k0;
         c_ff[c][0] <= 24'(2*k1);
         // stages 1..3: horner steps
         c2_ff[c] <= crs_pkg::rnd_mul(c_ff[c][3], u_ff[0]) + c_ff[c][2];
         c1_ff[c][0] <= c_ff[c][1];
         c0_ff[c][0] <= c_ff[c][0];
         h_ff[c] <= crs_pkg::rnd_mul(c2_ff[c], u_ff[1]) + c1_ff[c][0];
         c0_ff[c][1] <= c0_ff[c][0];
         c1_ff[c][1] <= crs_pkg::rnd_mul(h_ff[c], u_ff[2]) + c0_ff[c][1];
         // stage 4: halve, round, saturate
         hf = (c1_ff[c][1] + 24'sd1) >>> 1;
         if (zero_ff[3]) o_ff[c] <= '0;
         else if (hf > 24'sd32767) o_ff[c] <= 16'sh7fff;
         else if (hf < -24'sd32768) o_ff[c] <= 16'sh8000;
         else o_ff[c] <= 16'(hf);
      end
   end

   assign res_valid = v_ff[4];
   assign res.red = o_ff[0];
   assign res.green = o_ff[1];
   assign res.blue = o_ff[2];

   `CRS_ASSERT(a_no_mix, clock, reset, !(op.is_eval && op.wr_en), "eval and write together")
   `CRS_ASSERT(a_lat, clock, reset, op.is_eval |-> ##5 res_valid, "result lost in pipe")
   `CRS_ASSERT(a_span, clock, reset, (op.is_eval && !op.zero) |-> (op.span <= 4'd12), "span past table end")
endmodule
`default_nettype wire

// File: src/crs_queue.sv
// result queue with credit-based fill tracking
`timescale 1ns / 1ps
`default_nettype none
`include "catmull_rom_color_spline_macros.svh"
module crs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire crs_pkg::rsp_type  wr_data,
   input  wire logic              rd_en,
   output crs_pkg::rsp_type       rd_data,
   output logic                   empty,
   input  wire logic              in_push,
   input  wire logic              in_eval,
   output logic                   full
);
   crs_pkg::rsp_type mem_ff [crs_pkg::QDepth];
   logic [crs_pkg::QPtrW-1:0] wp_ff, rp_ff;
   logic [crs_pkg::QPtrW:0] cnt_ff, cnt_in;
   // results in flight plus stored, reserved at accept
   logic [crs_pkg::QPtrW:0] rsv_ff, rsv_in;

   always_comb begin
      cnt_in = cnt_ff + (crs_pkg::QPtrW+1)'(wr_en) - (crs_pkg::QPtrW+1)'(rd_en);
      rsv_in = rsv_ff + (crs_pkg::QPtrW+1)'(in_push && in_eval)
               - (crs_pkg::QPtrW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; rsv_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + crs_pkg::QPtrW'(1);
         if (rd_en) rp_ff <= rp_ff + crs_pkg::QPtrW'(1);
         cnt_ff <= cnt_in;
         rsv_ff <= rsv_in;
      end
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   assign rd_data = mem_ff[rp_ff];
   assign empty = (cnt_ff == '0);
   assign full = (rsv_ff >= (crs_pkg::QPtrW+1)'(crs_pkg::QDepth));

   `CRS_ASSERT(a_cnt, clock, reset, cnt_ff <= rsv_ff, "stored exceeds reserved")
   `CRS_ASSERT(a_ovf, clock, reset, !(wr_en && cnt_ff == (crs_pkg::QPtrW+1)'(crs_pkg::QDepth)), "queue overflow")
   `CRS_ASSERT(a_rsv, clock, reset, rsv_ff <= (crs_pkg::QPtrW+1)'(crs_pkg::QDepth), "reservation overflow")
endmodule
`default_nettype wire

// File: src/catmull_rom_color_spline.sv
// top level: catmull-rom color spline with queue handshakes
// an evaluate passes the front register, the back pipeline and the result queue to rsp ports
// throughput: one transaction per cycle while not full, writes and evaluates alike
// the horner chain is a 3-multiply pipeline; an 8-entry result queue decouples pop
// reset: synchronous active high; knot_count returns to 13, queue empties
// knot tables are not cleared; read only knots that were written
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_color_spline (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire crs_pkg::req_type  req_data,
   output logic                   empty,
   input  wire logic              pop,
   output crs_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic [4:0]        csr_wdata
);
   logic [4:0] knot_count_ff;
   logic accept;
   crs_pkg::op_type op;
   logic res_valid;
   crs_pkg::rsp_type res;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) knot_count_ff <= 5'd13;
      else if (csr_we) knot_count_ff <= csr_wdata;
   end

   assign accept = push && !full;

   // front: classify transaction, compute span and fraction
   crs_front u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .in_req(req_data),
      .knot_count(knot_count_ff), .op_ff(op)
   );

   // back: knot tables and horner pipeline
   crs_back u_back (
      .clock(clock), .reset(reset), .op(op), .res_valid(res_valid), .res(res)
   );

   // result queue, reserved at accept so pipeline never stalls
   crs_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(res_valid), .wr_data(res),
      .rd_en(pop && !empty), .rd_data(rsp_data), .empty(empty),
      .in_push(accept), .in_eval(req_data.cmd == crs_pkg::CMD_EVAL), .full(full)
   );
endmodule
`default_nettype wire
